/* hw/rtl/crc8fr_pkg.sv */
package crc8fr_pkg;

	localparam logic [7:0] CRC_POLY         = 8'h07;
	localparam logic [7:0] CRC_INIT         = 8'h00;
	localparam logic [7:0] START_BYTE_RESET = 8'hAA;

	localparam logic KIND_PAYLOAD   = 1'b0;
	localparam logic KIND_FRAME_END = 1'b1;

	// The request held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

	// One result request as computed by the parser.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_type;
		logic [7:0] payload_length;
		logic       crc_good;
	} result_t;

	// CRC-8, polynomial 0x07, MSB first, one byte at a time.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hw/rtl/crc8fr_ifs.sv */
interface crc8fr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [7:0] frame_type;
	logic [7:0] payload_length;
	logic       crc_good;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output frame_type, output payload_length, output crc_good, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input frame_type, input payload_length, input crc_good, output ready);
endinterface

/* hw/rtl/crc8_frame_receiver.sv */
// CRC-8 length-prefixed frame receiver.
//
// Received bytes come in as requests on rx, one byte each. The block drops
// bytes until it sees the start byte, then takes a length byte, a type byte,
// that many payload bytes and a CRC byte. Every payload byte leaves on res as
// a payload request carrying its index, and the CRC byte produces one frame-end
// request that reports the type, the length and whether the CRC-8 (poly 0x07,
// init 0) over length, type and payload matched. Hunting resumes after each
// frame, good or bad. Start, length and type bytes produce no request.
// The start byte is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// A byte accepted on rx is parsed while it sits in the input register, and
// its result is loaded into the result register once that register can take
// it, so each result reaches res through the input and result registers. One
// byte is accepted every cycle while res does not stall; the rate is set by the
// single parse step between the input and result registers.
// Reset clears the frame state to hunting and the start byte to 0xAA.
// When res is stalled the result register holds, the input register keeps one
// more byte, and rx.ready drops only once both are full.
module crc8_frame_receiver
	import crc8fr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	crc8fr_byte_if.sink     rx,
	crc8fr_result_if.source res
);

	logic       [7:0] start_byte_q;
	stage_t           st_s1;
	logic             advance;
	logic             res_valid;
	result_t          res_d;

	// Start-of-frame marker register; it takes effect at the next hunt compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RESET;
		end else if (cfg_we) begin
			start_byte_q <= cfg_wdata;
		end
	end

	crc8fr_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.st_s1   (st_s1)
	);

	crc8fr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.st_s1      (st_s1),
		.advance    (advance),
		.start_byte (start_byte_q),
		.res_valid  (res_valid),
		.res_d      (res_d)
	);

	crc8fr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_d     (res_d),
		.advance   (advance),
		.res       (res)
	);

	// Backpressure on rx only when both registers hold a request and res stalls.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (st_s1.valid && res.valid && !res.ready))
		else $error("rx stalled while a register was free");

	// A frame-end request never carries payload data.
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_FRAME_END) |->
		(res.data_byte == 8'd0 && res.byte_index == 8'd0))
		else $error("frame end carries payload fields");

	// A payload request never claims a CRC result, and its index lies inside the frame.
	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_PAYLOAD) |->
		(!res.crc_good && res.byte_index < res.payload_length))
		else $error("payload request with bad CRC flag or index");

	// The parser never produces a result unless a byte is moving out of the input register.
	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (st_s1.valid && advance))
		else $error("result without a byte to parse");

endmodule

/* hw/rtl/crc8fr_in_stage.sv */
module crc8fr_in_stage
	import crc8fr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	crc8fr_byte_if.sink  rx,
	input  logic         advance,
	output stage_t       st_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// The register frees up whenever its content moves on in the same cycle.
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign st_s1 = '{valid: valid_s1, rx_byte: byte_s1};

endmodule

/* hw/rtl/crc8fr_parser.sv */
module crc8fr_parser
	import crc8fr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  stage_t     st_s1,
	input  logic       advance,
	input  logic [7:0] start_byte,
	output logic       res_valid,
	output result_t    res_d
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_TYPE    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] type_q, type_d;
	logic [7:0] count_q, count_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] count_inc;
	logic [7:0] b;
	logic       process;

	assign process   = st_s1.valid && advance;
	assign b         = st_s1.rx_byte;
	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		type_d    = type_q;
		count_d   = count_q;
		crc_d     = crc_q;
		res_valid = 1'b0;
		res_d.kind           = KIND_PAYLOAD;
		res_d.data_byte      = 8'd0;
		res_d.byte_index     = 8'd0;
		res_d.frame_type     = type_q;
		res_d.payload_length = len_q;
		res_d.crc_good       = 1'b0;
		if (process) begin
			case (phase_q)
				PH_LEN: begin
					len_d   = b;
					crc_d   = crc8_byte(CRC_INIT, b);
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					type_d  = b;
					crc_d   = crc8_byte(crc_q, b);
					count_d = 8'd0;
					phase_d = (len_q == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res_d.data_byte  = b;
					res_d.byte_index = count_q;
					crc_d            = crc8_byte(crc_q, b);
					count_d          = count_inc;
					if (count_inc == len_q) begin
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					res_valid      = 1'b1;
					res_d.kind     = KIND_FRAME_END;
					res_d.crc_good = (crc_q == b);
					phase_d        = PH_HUNT;
				end
				default: begin
					// Hunting, and any code that means nothing falls back to it.
					phase_d = (b == start_byte) ? PH_LEN : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= 8'd0;
			type_q  <= 8'd0;
			count_q <= 8'd0;
			crc_q   <= CRC_INIT;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			type_q  <= type_d;
			count_q <= count_d;
			crc_q   <= crc_d;
		end
	end

endmodule

/* hw/rtl/crc8fr_out_reg.sv */
module crc8fr_out_reg
	import crc8fr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	input  result_t         res_d,
	output logic            advance,
	crc8fr_result_if.source res
);

	logic    valid_q;
	result_t data_q;

	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			data_q <= res_d;
		end
	end

	assign res.valid          = valid_q;
	assign res.kind           = data_q.kind;
	assign res.data_byte      = data_q.data_byte;
	assign res.byte_index     = data_q.byte_index;
	assign res.frame_type     = data_q.frame_type;
	assign res.payload_length = data_q.payload_length;
	assign res.crc_good       = data_q.crc_good;

endmodule

/* bench/crc8fr_checker.sv */
module crc8fr_checker
	import crc8fr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	crc8fr_byte_if     rx,
	crc8fr_result_if   res,
	output int         errors,
	output int         outstanding
);

	typedef enum logic [2:0] {HUNT, GET_LEN, GET_TYPE, GET_PAYLOAD, GET_CRC} parse_phase_t;

	parse_phase_t phase;
	logic [7:0]   marker;
	logic [7:0]   frame_len;
	logic [7:0]   frame_type;
	logic [7:0]   payload_idx;
	logic [7:0]   crc_acc;
	result_t      awaited[$];

	// CRC-8, polynomial 0x07, fed one bit at a time, MSB first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		case (phase)
			GET_LEN: begin
				frame_len = b;
				crc_acc = crc8_step(CRC_INIT, b);
				phase = GET_TYPE;
			end
			GET_TYPE: begin
				frame_type = b;
				crc_acc = crc8_step(crc_acc, b);
				payload_idx = 8'd0;
				phase = (frame_len == 8'd0) ? GET_CRC : GET_PAYLOAD;
			end
			GET_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.byte_index = payload_idx;
				r.frame_type = frame_type;
				r.payload_length = frame_len;
				awaited.push_back(r);
				crc_acc = crc8_step(crc_acc, b);
				payload_idx = payload_idx + 8'd1;
				if (payload_idx == frame_len) begin
					phase = GET_CRC;
				end
			end
			GET_CRC: begin
				r.kind = KIND_FRAME_END;
				r.frame_type = frame_type;
				r.payload_length = frame_len;
				r.crc_good = (crc_acc == b);
				awaited.push_back(r);
				phase = HUNT;
			end
			default: begin
				phase = (b == marker) ? GET_LEN : HUNT;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result();
		result_t want;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, got kind %0h data %0h index %0h",
				$time, res.kind, res.data_byte, res.byte_index);
			return;
		end
		want = awaited.pop_front();
		check_field("kind", want.kind, res.kind);
		check_field("data_byte", want.data_byte, res.data_byte);
		check_field("byte_index", want.byte_index, res.byte_index);
		check_field("frame_type", want.frame_type, res.frame_type);
		check_field("payload_length", want.payload_length, res.payload_length);
		check_field("crc_good", want.crc_good, res.crc_good);
	endfunction

	// Results are compared before new bytes are parsed, so a spurious result can
	// never match an expectation queued at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker = START_BYTE_RESET;
			phase = HUNT;
			frame_len = 8'd0;
			frame_type = 8'd0;
			payload_idx = 8'd0;
			crc_acc = CRC_INIT;
			awaited.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				marker = cfg_wdata;
			end
			if (res.valid && res.ready) begin
				check_result();
			end
			if (rx.valid && rx.ready) begin
				parse_byte(rx.rx_byte);
			end
		end
		outstanding = awaited.size();
	end

endmodule

/* bench/tb.sv */
// Bench top for the CRC-8 frame receiver. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the frame monitor,
// which watches both channels and the start-byte writes.
module tb;
	import crc8fr_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         errors;
	int         outstanding;

	crc8fr_byte_if   rx_ch();
	crc8fr_result_if res_ch();

	crc8_frame_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	crc8fr_checker frame_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rx          (rx_ch),
		.res         (res_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// The start byte currently programmed, used to build frames that the block
	// will actually lock onto.
	logic [7:0] start_val;
	// Payload of the next frame to send; its size is the declared length.
	logic [7:0] payload_q[$];
	// Bytes sent as part of frames; hunting noise does not count.
	int         frame_items;
	// Sender burst state. While steady is set the sender never pauses.
	int         burst_left;
	bit         steady;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Safety net: the slowest legal run is far shorter than this.
	initial begin
		#7_200_000;
		$display("Some tests failed");
		$finish;
	end

	// The result side stalls on its own pattern: fully open, randomly stalled,
	// or a fixed duty cycle with short or long stalls, switching mode after a random
	// span so stalls land on every phase of a frame.
	initial begin
		int mode;
		int span;
		res_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 80);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					0: begin
						res_ch.ready <= 1'b1;
					end
					1: begin
						res_ch.ready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						res_ch.ready <= ((i % 7) < 4);
					end
					default: begin
						res_ch.ready <= ((i % 12) < 2);
					end
				endcase
			end
		end
	end

	// Independent CRC-8 used only to build correct frames for the stimulus.
	function automatic logic [7:0] frame_crc(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) begin
			c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
		end
		return c;
	endfunction

	// Sends one byte request. Before a new burst starts the sender may pause
	// unless steady is set; valid stays high across back-to-back requests in a burst.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				rx_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
	endtask

	// Sends start, length, type, the queued payload and the CRC byte. A bad
	// frame gets one CRC bit flipped; a nonzero cut stops the frame after that
	// many bytes so the block is left mid-frame.
	task automatic send_frame(input logic [7:0] ftype, input bit bad_crc, input int cut);
		logic [7:0] fb[$];
		logic [7:0] c;
		int         n;
		fb.push_back(start_val);
		fb.push_back(8'(payload_q.size()));
		fb.push_back(ftype);
		foreach (payload_q[i]) fb.push_back(payload_q[i]);
		c = CRC_INIT;
		for (int i = 1; i < fb.size(); i++) c = frame_crc(c, fb[i]);
		if (bad_crc) begin
			c = c ^ (8'h01 << $urandom_range(0, 7));
		end
		fb.push_back(c);
		n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
		for (int i = 0; i < n; i++) send_byte(fb[i]);
		frame_items += n;
	endtask

	// Lets the block drain: every expected result must have left, and a final wait
	// lets a byte that makes no result leave the pipeline as well.
	task automatic settle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_start(input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		start_val = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random step: mostly well-formed frames with random content, some with
	// a bad CRC, some cut short, and some hunting noise. Lengths stay small, with
	// a rare long frame of 128 to 255 bytes.
	task automatic random_step();
		int         r;
		int         len;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		steady = ($urandom_range(0, 5) == 0);
		if (r < 12) begin
			repeat ($urandom_range(1, 4)) begin
				b = $urandom_range(0, 255);
				// Noise mostly avoids the marker so that frames get recognized.
				if (b == start_val && $urandom_range(0, 3) != 0) begin
					b = ~b;
				end
				send_byte(b);
			end
		end else begin
			len = ($urandom_range(0, 79) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 10);
			payload_q.delete();
			repeat (len) payload_q.push_back($urandom_range(0, 255));
			send_frame($urandom_range(0, 255), (r >= 80 && r < 90),
				(r >= 90) ? $urandom_range(1, len + 3) : 0);
		end
	endtask

	initial begin
		logic [7:0] starts[5];
		int         target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		start_val = START_BYTE_RESET;
		frame_items = 0;
		burst_left = 0;
		steady = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with the start byte at its reset value. Extreme bytes
		// while hunting are dropped.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Zero-length frame: the byte after the type is the CRC.
		payload_q.delete();
		send_frame(8'hFF, 1'b0, 0);
		// The start byte inside a frame is plain payload; this frame has a bad CRC
		// and the block must hunt again right after it.
		payload_q = '{8'h00, START_BYTE_RESET, 8'hFF};
		send_frame(8'h00, 1'b1, 0);
		payload_q = '{8'h80};
		send_frame(8'h7E, 1'b0, 0);

		// Random part, run under several start byte settings, the extremes first
		// and the reset value again at the end.
		starts[0] = 8'h00;
		starts[1] = 8'hFF;
		starts[2] = $urandom_range(1, 254);
		starts[3] = $urandom_range(1, 254);
		starts[4] = START_BYTE_RESET;
		foreach (starts[p]) begin
			settle();
			write_start(starts[p]);
			target = frame_items + 330;
			while (frame_items < target) random_step();
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/crc8fr_pkg.sv
hw/rtl/crc8fr_ifs.sv
hw/rtl/crc8fr_in_stage.sv
hw/rtl/crc8fr_parser.sv
hw/rtl/crc8fr_out_reg.sv
hw/rtl/crc8_frame_receiver.sv
bench/crc8fr_checker.sv
bench/tb.sv
